// ===== hdl/svn_wire_token_lexer_core_assert.svh =====
// Assertion macros used by the lexer's result queue.
`ifndef SVN_WIRE_TOKEN_LEXER_CORE_ASSERT_SVH
`define SVN_WIRE_TOKEN_LEXER_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SWTL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lexer assertion failed");

// next-cycle implication, disabled in reset
`define SWTL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lexer assertion failed");

`endif

// ===== hdl/swtl_pkg.sv =====
// Types and constants for the wire token lexer.
package swtl_pkg;

    localparam int VALUE_W       = 63;
    localparam int DEPTH_FIELD_W = 8;
    localparam int NEST_W        = 5;
    localparam int Q_DEPTH       = 4;
    localparam int Q_CNT_W       = 3;

    localparam logic [VALUE_W-1:0] NUM_LIMIT      = 63'd922337203685477580;
    localparam logic [3:0]         MAX_LAST_DIGIT = 4'd7;

    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_Z   = 8'h7A;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5A;

    typedef enum logic [2:0] {
        K_OPEN,
        K_CLOSE,
        K_NUMBER,
        K_WORD_BYTE,
        K_WORD_END,
        K_STR_START,
        K_STR_BYTE,
        K_ERROR
    } t_kind;

    typedef enum logic [2:0] {
        E_NONE,
        E_BAD_CHAR,
        E_TOO_BIG,
        E_STRAY_CLOSE,
        E_DEPTH,
        E_EARLY_END
    } t_err;

    typedef enum logic [1:0] {
        M_IDLE,
        M_NUMBER,
        M_WORD,
        M_STRING
    } t_mode;

    typedef struct packed {
        t_kind                    kind;
        logic [VALUE_W-1:0]       value;
        logic [7:0]               data;
        logic [DEPTH_FIELD_W-1:0] depth;
        t_err                     err;
        logic                     last;
    } t_token;

    typedef struct packed {
        logic [1:0] cnt;
        t_token     tok0;
        t_token     tok1;
    } t_push;

endpackage

// ===== hdl/swtl_lexer.sv =====
// Lexer state and the per-byte token step.
module swtl_lexer #(
    parameter int MAX_DEPTH = 16,
    parameter int DEPTH_W   = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_stream_end,
    output swtl_pkg::t_push      o_push
);

    typedef struct packed {
        logic                           hit;
        swtl_pkg::t_token               tok;
        swtl_pkg::t_mode                mode;
        logic [swtl_pkg::VALUE_W-1:0]   acc;
        logic [DEPTH_W-1:0]             depth;
    } t_idle;

    typedef struct packed {
        logic [1:0]                     cnt;
        swtl_pkg::t_token               tok0;
        swtl_pkg::t_token               tok1;
        swtl_pkg::t_mode                mode;
        logic [swtl_pkg::VALUE_W-1:0]   acc;
        logic [DEPTH_W-1:0]             depth;
    } t_lex;

    swtl_pkg::t_mode                r_mode, n_mode;
    logic [swtl_pkg::VALUE_W-1:0]   r_acc, n_acc;
    logic [DEPTH_W-1:0]             r_depth, n_depth;

    t_idle w_idle;
    t_lex  w_lex;

    function automatic swtl_pkg::t_token mk_tok(
        input swtl_pkg::t_kind              kind,
        input logic [swtl_pkg::VALUE_W-1:0] value,
        input logic [7:0]                   data,
        input logic [DEPTH_W-1:0]           depth
    );
        swtl_pkg::t_token t;
        t.kind  = kind;
        t.value = value;
        t.data  = data;
        t.depth = swtl_pkg::DEPTH_FIELD_W'(depth);
        t.err   = swtl_pkg::E_NONE;
        t.last  = 1'b0;
        return t;
    endfunction

    function automatic swtl_pkg::t_token err_tok(
        input swtl_pkg::t_err e,
        input logic [7:0]     data
    );
        swtl_pkg::t_token t;
        t.kind  = swtl_pkg::K_ERROR;
        t.value = '0;
        t.data  = data;
        t.depth = '0;
        t.err   = e;
        t.last  = 1'b0;
        return t;
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return (ch >= swtl_pkg::CH_ZERO) && (ch <= swtl_pkg::CH_NINE);
    endfunction

    function automatic logic is_letter(input logic [7:0] ch);
        return ((ch >= swtl_pkg::CH_LC_A) && (ch <= swtl_pkg::CH_LC_Z)) ||
               ((ch >= swtl_pkg::CH_UC_A) && (ch <= swtl_pkg::CH_UC_Z));
    endfunction

    function automatic t_idle idle_step(
        input logic [7:0]         ch,
        input logic               fin,
        input logic [DEPTH_W-1:0] d
    );
        t_idle r;
        r.hit   = 1'b0;
        r.tok   = '0;
        r.mode  = swtl_pkg::M_IDLE;
        r.acc   = '0;
        r.depth = d;
        if (fin) begin
            if (d != '0) begin
                r.hit   = 1'b1;
                r.tok   = err_tok(swtl_pkg::E_EARLY_END, 8'd0);
                r.depth = '0;
            end
        end else if ((ch == swtl_pkg::CH_SPACE) || (ch == swtl_pkg::CH_NL)) begin
            r.hit = 1'b0;
        end else if (ch == swtl_pkg::CH_LPAREN) begin
            r.hit = 1'b1;
            if (d == DEPTH_W'(MAX_DEPTH)) begin
                r.tok   = err_tok(swtl_pkg::E_DEPTH, ch);
                r.depth = '0;
            end else begin
                r.depth = d + 1'b1;
                r.tok   = mk_tok(swtl_pkg::K_OPEN, '0, 8'd0, d + 1'b1);
            end
        end else if (ch == swtl_pkg::CH_RPAREN) begin
            r.hit = 1'b1;
            if (d == '0) begin
                r.tok = err_tok(swtl_pkg::E_STRAY_CLOSE, ch);
            end else begin
                r.depth = d - 1'b1;
                r.tok   = mk_tok(swtl_pkg::K_CLOSE, '0, 8'd0, d - 1'b1);
            end
        end else if (is_digit(ch)) begin
            r.mode = swtl_pkg::M_NUMBER;
            r.acc  = swtl_pkg::VALUE_W'(ch - swtl_pkg::CH_ZERO);
        end else if (is_letter(ch)) begin
            r.hit  = 1'b1;
            r.mode = swtl_pkg::M_WORD;
            r.tok  = mk_tok(swtl_pkg::K_WORD_BYTE, '0, ch, d);
        end else begin
            r.hit   = 1'b1;
            r.tok   = err_tok(swtl_pkg::E_BAD_CHAR, ch);
            r.depth = '0;
        end
        return r;
    endfunction

    always_comb begin
        w_idle = idle_step(i_rx_byte, i_stream_end, r_depth);
    end

    always_comb begin
        logic [3:0]                   digit;
        logic [swtl_pkg::VALUE_W-1:0] dec;
        digit       = 4'(i_rx_byte - swtl_pkg::CH_ZERO);
        dec         = (r_acc != '0) ? (r_acc - 1'b1) : r_acc;
        w_lex.cnt   = 2'd0;
        w_lex.tok0  = '0;
        w_lex.tok1  = '0;
        w_lex.mode  = r_mode;
        w_lex.acc   = r_acc;
        w_lex.depth = r_depth;
        unique case (r_mode)
            swtl_pkg::M_IDLE: begin
                w_lex.cnt   = {1'b0, w_idle.hit};
                w_lex.tok0  = w_idle.tok;
                w_lex.mode  = w_idle.mode;
                w_lex.acc   = w_idle.acc;
                w_lex.depth = w_idle.depth;
            end
            swtl_pkg::M_NUMBER: begin
                if (!i_stream_end && is_digit(i_rx_byte)) begin
                    if ((r_acc > swtl_pkg::NUM_LIMIT) ||
                        ((r_acc == swtl_pkg::NUM_LIMIT) &&
                         (digit > swtl_pkg::MAX_LAST_DIGIT))) begin
                        w_lex.cnt   = 2'd1;
                        w_lex.tok0  = err_tok(swtl_pkg::E_TOO_BIG, i_rx_byte);
                        w_lex.mode  = swtl_pkg::M_IDLE;
                        w_lex.acc   = '0;
                        w_lex.depth = '0;
                    end else begin
                        w_lex.acc = {r_acc[swtl_pkg::VALUE_W-4:0], 3'b000}
                                  + {r_acc[swtl_pkg::VALUE_W-2:0], 1'b0}
                                  + swtl_pkg::VALUE_W'(digit);
                    end
                end else if (!i_stream_end && (i_rx_byte == swtl_pkg::CH_COLON)) begin
                    w_lex.cnt  = 2'd1;
                    w_lex.tok0 = mk_tok(swtl_pkg::K_STR_START, r_acc, 8'd0, r_depth);
                    w_lex.mode = (r_acc != '0) ? swtl_pkg::M_STRING : swtl_pkg::M_IDLE;
                end else begin
                    w_lex.cnt   = 2'd1 + {1'b0, w_idle.hit};
                    w_lex.tok0  = mk_tok(swtl_pkg::K_NUMBER, r_acc, 8'd0, r_depth);
                    w_lex.tok1  = w_idle.tok;
                    w_lex.mode  = w_idle.mode;
                    w_lex.acc   = w_idle.acc;
                    w_lex.depth = w_idle.depth;
                end
            end
            swtl_pkg::M_WORD: begin
                if (!i_stream_end && (is_letter(i_rx_byte) || is_digit(i_rx_byte) ||
                                      (i_rx_byte == swtl_pkg::CH_DASH))) begin
                    w_lex.cnt  = 2'd1;
                    w_lex.tok0 = mk_tok(swtl_pkg::K_WORD_BYTE, '0, i_rx_byte, r_depth);
                end else begin
                    w_lex.cnt   = 2'd1 + {1'b0, w_idle.hit};
                    w_lex.tok0  = mk_tok(swtl_pkg::K_WORD_END, '0, 8'd0, r_depth);
                    w_lex.tok1  = w_idle.tok;
                    w_lex.mode  = w_idle.mode;
                    w_lex.acc   = w_idle.acc;
                    w_lex.depth = w_idle.depth;
                end
            end
            swtl_pkg::M_STRING: begin
                w_lex.cnt = 2'd1;
                if (i_stream_end) begin
                    w_lex.tok0  = err_tok(swtl_pkg::E_EARLY_END, 8'd0);
                    w_lex.mode  = swtl_pkg::M_IDLE;
                    w_lex.acc   = '0;
                    w_lex.depth = '0;
                end else begin
                    w_lex.tok0 = mk_tok(swtl_pkg::K_STR_BYTE, dec, i_rx_byte, r_depth);
                    w_lex.acc  = dec;
                    if (dec == '0) begin
                        w_lex.mode = swtl_pkg::M_IDLE;
                    end
                end
            end
            default: begin
                w_lex.cnt = 2'd0;
            end
        endcase
        if (w_lex.cnt == 2'd1) begin
            w_lex.tok0.last = 1'b1;
        end
        if (w_lex.cnt == 2'd2) begin
            w_lex.tok1.last = 1'b1;
        end
    end

    // next state
    always_comb begin
        n_mode  = r_mode;
        n_acc   = r_acc;
        n_depth = r_depth;
        if (i_accept) begin
            n_mode  = w_lex.mode;
            n_acc   = w_lex.acc;
            n_depth = w_lex.depth;
        end
    end

    // outputs
    always_comb begin
        o_push.cnt  = i_accept ? w_lex.cnt : 2'd0;
        o_push.tok0 = w_lex.tok0;
        o_push.tok1 = w_lex.tok1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= swtl_pkg::M_IDLE;
            r_acc   <= '0;
            r_depth <= '0;
        end else begin
            r_mode  <= n_mode;
            r_acc   <= n_acc;
            r_depth <= n_depth;
        end
    end

endmodule

// ===== hdl/swtl_out_queue.sv =====
// Result queue: takes up to two tokens per cycle while it has room, delivers one per transfer.
module swtl_out_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  swtl_pkg::t_push    i_push,
    output logic               o_room,
    output logic               o_valid,
    input  logic               i_ready,
    output swtl_pkg::t_token   o_tok
);

`include "svn_wire_token_lexer_core_assert.svh"

    swtl_pkg::t_token               r_q [swtl_pkg::Q_DEPTH];
    swtl_pkg::t_token               n_q [swtl_pkg::Q_DEPTH];
    logic [swtl_pkg::Q_CNT_W-1:0]   r_cnt, n_cnt;
    logic                           w_pop;
    logic [swtl_pkg::Q_CNT_W-1:0]   w_base;

    assign o_valid = (r_cnt != '0);
    assign o_tok   = r_q[0];
    assign o_room  = (r_cnt <= swtl_pkg::Q_CNT_W'(swtl_pkg::Q_DEPTH - 2));
    assign w_pop   = o_valid && i_ready;
    assign w_base  = r_cnt - swtl_pkg::Q_CNT_W'(w_pop);
    assign n_cnt   = w_base + swtl_pkg::Q_CNT_W'(i_push.cnt);

    always_comb begin
        for (int i = 0; i < swtl_pkg::Q_DEPTH; i++) begin
            if (w_pop && (i < swtl_pkg::Q_DEPTH - 1)) begin
                n_q[i] = r_q[(i + 1) % swtl_pkg::Q_DEPTH];
            end else begin
                n_q[i] = r_q[i];
            end
            if ((i_push.cnt != 2'd0) && (swtl_pkg::Q_CNT_W'(i) == w_base)) begin
                n_q[i] = i_push.tok0;
            end
            if ((i_push.cnt == 2'd2) && (swtl_pkg::Q_CNT_W'(i) == w_base + 1'b1)) begin
                n_q[i] = i_push.tok1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    `SWTL_ASSERT_NOW(a_push_room, i_push.cnt != 2'd0, o_room)
    `SWTL_ASSERT_NOW(a_cnt_bound, 1'b1, r_cnt <= swtl_pkg::Q_CNT_W'(swtl_pkg::Q_DEPTH))
    `SWTL_ASSERT_NOW(a_err_clean, o_valid && (o_tok.kind == swtl_pkg::K_ERROR),
                     (o_tok.depth == '0) && (o_tok.value == '0) && o_tok.last)
    `SWTL_ASSERT_NEXT(a_pop_only, w_pop && (i_push.cnt == 2'd0),
                      r_cnt == $past(r_cnt) - 1'b1)

endmodule

// ===== hdl/svn_wire_token_lexer_core.sv =====
// Top level of the wire token lexer: byte in, list/number/word/string/error tokens out.
// A token is registered in the result queue before it is offered on the output.
// Throughput: one byte per cycle; bytes giving two tokens need two output transfers,
//   and the four-entry result queue takes a byte whenever two entries are free.
// Reset (synchronous, active low): idle mode, zero accumulator and depth, empty queue.
module svn_wire_token_lexer_core #(
    parameter int MAX_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_rx_byte,
    input  logic                          i_stream_end,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [2:0]                    o_token_kind,
    output logic [swtl_pkg::VALUE_W-1:0]  o_number_value,
    output logic [7:0]                    o_data_byte,
    output logic [swtl_pkg::NEST_W-1:0]   o_nest_depth,
    output logic [2:0]                    o_error_code,
    output logic                          o_last
);

    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

    swtl_pkg::t_push  w_push;
    swtl_pkg::t_token w_tok;
    logic             w_accept;

    assign w_accept = i_in_valid && o_in_ready;

    swtl_lexer #(
        .MAX_DEPTH (MAX_DEPTH),
        .DEPTH_W   (DEPTH_W)
    ) u_lexer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_rx_byte    (i_rx_byte),
        .i_stream_end (i_stream_end),
        .o_push       (w_push)
    );

    swtl_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_tok   (w_tok)
    );

    assign o_token_kind   = w_tok.kind;
    assign o_number_value = w_tok.value;
    assign o_data_byte    = w_tok.data;
    assign o_nest_depth   = w_tok.depth[swtl_pkg::NEST_W-1:0];
    assign o_error_code   = w_tok.err;
    assign o_last         = w_tok.last;

endmodule
